[src/pmst_pkg.sv]
package pmst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int VX_W         = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VX_W + 1;
    localparam int KEY_W        = WEIGHT_BITS + 1;
    localparam int ADDR_W       = 2 * VX_W;
    localparam int EDGE_W       = WEIGHT_BITS + 1;
    localparam int MEM_DEPTH    = MAX_VERTICES * MAX_VERTICES;

    localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRE,
        ST_WAVE,
        ST_EMIT
    } t_state;

    // One token travels down the cell row per step, carrying the running minimum.
    typedef struct packed {
        logic             tok;
        logic [KEY_W-1:0] best_key;
        logic [VX_W-1:0]  best_idx;
    } t_wave;

endpackage

[src/pmst_in_if.sv]
interface pmst_in_if;
    import pmst_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [VX_W-1:0]        from_vertex;
    logic [VX_W-1:0]        to_vertex;
    logic [WEIGHT_BITS-1:0] weight;
    modport source (output valid, cmd, from_vertex, to_vertex, weight, input ready);
    modport sink   (input valid, cmd, from_vertex, to_vertex, weight, output ready);
endinterface

[src/pmst_out_if.sv]
interface pmst_out_if;
    import pmst_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [VX_W-1:0]        child_vertex;
    logic [VX_W-1:0]        parent_vertex;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic                   reachable;
    logic                   last;
    modport source (output valid, child_vertex, parent_vertex, edge_weight, reachable, last,
                    input ready);
    modport sink   (input valid, child_vertex, parent_vertex, edge_weight, reachable, last,
                    output ready);
endinterface

[src/pmst_cfg_if.sv]
interface pmst_cfg_if;
    import pmst_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/pmst_ram.sv]
module pmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/pmst_cell.sv]
module pmst_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_init,
    input  logic [pmst_pkg::VX_W-1:0]       i_idx,
    input  logic [pmst_pkg::CNT_W-1:0]      i_n,
    input  logic [pmst_pkg::VX_W-1:0]       i_u,
    input  logic [pmst_pkg::EDGE_W-1:0]     i_edge,
    input  pmst_pkg::t_wave                 i_wave,
    output pmst_pkg::t_wave                 o_wave,
    output logic [pmst_pkg::KEY_W-1:0]      o_key,
    output logic [pmst_pkg::VX_W-1:0]       o_parent,
    output logic                            o_has
);
    import pmst_pkg::*;

    logic [KEY_W-1:0] r_key, n_key;
    logic             r_vis, n_vis;
    logic             r_has;
    logic [VX_W-1:0]  r_par;
    t_wave            r_out, n_out;
    logic             act, relax, elig;

    always_comb begin
        act   = i_wave.tok && ({1'b0, i_idx} < i_n);
        relax = act && (i_idx != i_u) && !r_vis && i_edge[EDGE_W-1]
                && ({1'b0, i_edge[WEIGHT_BITS-1:0]} < r_key);
        n_key = relax ? {1'b0, i_edge[WEIGHT_BITS-1:0]} : r_key;
        n_vis = r_vis | (act && (i_idx == i_u));
        elig  = act && !n_vis;
        n_out = i_wave;
        // Strict compare keeps the lowest index on ties, since the token moves upward.
        if (elig && (n_key < i_wave.best_key)) begin
            n_out.best_key = n_key;
            n_out.best_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.tok <= 1'b0;
            r_vis     <= 1'b0;
            r_has     <= 1'b0;
        end else begin
            r_out <= n_out;
            if (i_init) begin
                r_vis <= 1'b0;
                r_has <= 1'b0;
            end else if (act) begin
                r_vis <= n_vis;
                if (relax) begin
                    r_has <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_key <= KEY_INF;
        end else if (act) begin
            r_key <= n_key;
            if (relax) begin
                r_par <= i_u;
            end
        end
    end

    assign o_wave   = r_out;
    assign o_key    = r_key;
    assign o_parent = r_par;
    assign o_has    = r_has;
endmodule

[src/prim_minimum_spanning_tree.sv]
// A clear item makes the block sweep the whole weight matrix; an add item writes one entry.
// A run takes one step per tree vertex found (at most 64 steps), each step set by
// one token crossing the 64-cell row while the matrix row streams from the memory port.
// Results follow at one per cycle while the sink takes them.
// Reset is synchronous, active low; it sets vertex_count to 64 and starts a clearing
// pass of the whole matrix, during which no item is accepted.
module prim_minimum_spanning_tree (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmst_in_if.sink     i_in,
    pmst_cfg_if.sink    i_cfg,
    pmst_out_if.source  o_out
);
    import pmst_pkg::*;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [VX_W-1:0]     r_u, n_u;
    logic [CNT_W-1:0]    r_vc;
    logic [VX_W-1:0]     r_ei, n_ei;
    logic                r_ov, n_ov;
    logic [VX_W-1:0]     r_child, r_par;
    logic [WEIGHT_BITS-1:0] r_w;
    logic                r_reach, r_last;
    logic                load;

    logic [CNT_W-1:0]    act_n;
    logic                in_acc, run_init;
    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [EDGE_W-1:0]   wdata, rdata;

    t_wave               w_wave [MAX_VERTICES+1];
    logic [KEY_W-1:0]    w_key  [MAX_VERTICES];
    logic [VX_W-1:0]     w_par  [MAX_VERTICES];
    logic                w_has  [MAX_VERTICES];

    always_comb begin
        if (r_vc == '0) begin
            act_n = CNT_W'(1);
        end else if (r_vc > CNT_W'(MAX_VERTICES)) begin
            act_n = CNT_W'(MAX_VERTICES);
        end else begin
            act_n = r_vc;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign run_init   = in_acc && (i_in.cmd == CMD_RUN);
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= CNT_W'(MAX_VERTICES);
        end else if (i_cfg.valid) begin
            r_vc <= i_cfg.data;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt;
        wdata = '0;
        if (r_state == ST_CLEAR) begin
            we = 1'b1;
        end else if (in_acc && (i_in.cmd == CMD_ADD)) begin
            we    = 1'b1;
            waddr = {i_in.from_vertex, i_in.to_vertex};
            wdata = {1'b1, i_in.weight};
        end
        // The entry for cell i is addressed ahead of the token, so the registered read data reaches cell i with it.
        if (r_state == ST_PRE) begin
            raddr = {r_u, {VX_W{1'b0}}};
        end else begin
            raddr = {r_u, r_cnt[VX_W-1:0] + VX_W'(1)};
        end
    end

    pmst_ram #(.WIDTH(EDGE_W), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        w_wave[0].tok      = (r_state == ST_WAVE) && (r_cnt == '0);
        w_wave[0].best_key = KEY_INF;
        w_wave[0].best_idx = '0;
    end

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        pmst_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_init   (run_init),
            .i_idx    (VX_W'(g)),
            .i_n      (act_n),
            .i_u      (r_u),
            .i_edge   (rdata),
            .i_wave   (w_wave[g]),
            .o_wave   (w_wave[g+1]),
            .o_key    (w_key[g]),
            .o_parent (w_par[g]),
            .o_has    (w_has[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_u     = r_u;
        n_ei    = r_ei;
        n_ov    = r_ov && !o_out.ready;
        load    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc) begin
                    case (i_in.cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_RUN: begin
                            n_state = ST_PRE;
                            n_u     = '0;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PRE: begin
                n_cnt   = '0;
                n_state = ST_WAVE;
            end
            ST_WAVE: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(MAX_VERTICES)) begin
                    if (w_wave[MAX_VERTICES].best_key[KEY_W-1]) begin
                        n_ei    = VX_W'(1);
                        n_state = (act_n >= CNT_W'(2)) ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_u     = w_wave[MAX_VERTICES].best_idx;
                        n_state = ST_PRE;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ov || o_out.ready) begin
                    load = 1'b1;
                    n_ov = 1'b1;
                    n_ei = r_ei + VX_W'(1);
                    if ({1'b0, r_ei} + CNT_W'(1) == act_n) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_u     <= '0;
            r_ei    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_u     <= n_u;
            r_ei    <= n_ei;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_child <= r_ei;
            r_reach <= w_has[r_ei];
            r_par   <= w_has[r_ei] ? w_par[r_ei] : '0;
            r_w     <= w_has[r_ei] ? w_key[r_ei][WEIGHT_BITS-1:0] : '0;
            r_last  <= ({1'b0, r_ei} + CNT_W'(1) == act_n);
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.child_vertex  = r_child;
    assign o_out.parent_vertex = r_par;
    assign o_out.edge_weight   = r_w;
    assign o_out.reachable     = r_reach;
    assign o_out.last          = r_last;
endmodule

[src/pmst_checker.sv]
module pmst_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_cmd,
    input logic       out_valid,
    input logic       out_ready
);
    import pmst_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !in_ready)
        else $error("input taken during matrix clearing");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_cmd == CMD_RUN) |=> !in_ready)
        else $error("input taken while a run is in progress");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_cmd == CMD_CLEAR) |=> !in_ready)
        else $error("input taken while the matrix is cleared");
endmodule

bind prim_minimum_spanning_tree pmst_props u_pmst_props (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_cmd    (i_in.cmd),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready)
);

[test/pmst_checker.sv]
`timescale 1ns / 100ps
module pmst_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmst_in_if         i_in,
    pmst_cfg_if        i_cfg,
    pmst_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending
);
    import pmst_pkg::*;

    typedef struct {
        logic [VX_W-1:0]        child;
        logic [VX_W-1:0]        parent;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   reach;
        logic                   last;
    } t_tree_edge;

    t_tree_edge tree_edges_q[$];
    logic                   edge_present[MEM_DEPTH];
    logic [WEIGHT_BITS-1:0] edge_wt[MEM_DEPTH];
    logic [CNT_W-1:0]       vcount;
    int                     fails;

    assign o_fail_count = fails;
    assign o_pending    = tree_edges_q.size();

    // Prim's algorithm with a linear minimum scan; results for vertices 1..n-1.
    task automatic solve_tree();
        int n, u, step, i;
        logic [KEY_W-1:0] key [MAX_VERTICES];
        logic             seen[MAX_VERTICES];
        int               par [MAX_VERTICES];
        logic [KEY_W-1:0] best;
        t_tree_edge       e;
        n = (vcount == 0) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
        for (i = 0; i < MAX_VERTICES; i++) begin
            key[i] = KEY_INF;
            seen[i] = 1'b0;
            par[i] = -1;
        end
        key[0] = '0;
        for (step = 0; step < n; step++) begin
            u = n;
            best = KEY_INF;
            for (i = 0; i < n; i++)
                if (!seen[i] && key[i] < best) begin
                    best = key[i];
                    u = i;
                end
            if (u >= n) break;
            seen[u] = 1'b1;
            for (i = 0; i < n; i++)
                if (!seen[i] && edge_present[u*MAX_VERTICES+i]
                    && {1'b0, edge_wt[u*MAX_VERTICES+i]} < key[i]) begin
                    key[i] = {1'b0, edge_wt[u*MAX_VERTICES+i]};
                    par[i] = u;
                end
        end
        for (i = 1; i < n; i++) begin
            e.child  = i[VX_W-1:0];
            e.reach  = (par[i] >= 0);
            e.parent = e.reach ? par[i][VX_W-1:0] : '0;
            e.weight = e.reach ? key[i][WEIGHT_BITS-1:0] : '0;
            e.last   = (i + 1 == n);
            tree_edges_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_tree_edge exp_e;
        if (!i_rst_n) begin
            vcount = 7'd64;
            fails = 0;
            tree_edges_q.delete();
            for (int i = 0; i < MEM_DEPTH; i++) edge_present[i] = 1'b0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (tree_edges_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result child %0d", $time, i_out.child_vertex);
                end else begin
                    exp_e = tree_edges_q.pop_front();
                    if (i_out.child_vertex !== exp_e.child || i_out.parent_vertex !== exp_e.parent
                        || i_out.edge_weight !== exp_e.weight
                        || i_out.reachable !== exp_e.reach || i_out.last !== exp_e.last) begin
                        fails++;
                        $display("%0t: mismatch exp c%0d p%0d w%0d r%0b l%0b got c%0d p%0d w%0d r%0b l%0b",
                                 $time, exp_e.child, exp_e.parent, exp_e.weight, exp_e.reach,
                                 exp_e.last, i_out.child_vertex, i_out.parent_vertex,
                                 i_out.edge_weight, i_out.reachable, i_out.last);
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) vcount = i_cfg.data;
            if (i_in.valid && i_in.ready) begin
                case (i_in.cmd)
                    CMD_CLEAR: for (int i = 0; i < MEM_DEPTH; i++) edge_present[i] = 1'b0;
                    CMD_ADD: begin
                        edge_present[i_in.from_vertex*MAX_VERTICES+i_in.to_vertex] = 1'b1;
                        edge_wt[i_in.from_vertex*MAX_VERTICES+i_in.to_vertex] = i_in.weight;
                    end
                    CMD_RUN: solve_tree();
                    default: ;
                endcase
            end
        end
    end
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
    import pmst_pkg::*;

    logic i_clk, i_rst_n;
    int   fail_count, pending, cycle_count;
    logic hold_sink;

    pmst_in_if  in_ch();
    pmst_cfg_if cfg_ch();
    pmst_out_if out_ch();

    prim_minimum_spanning_tree u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .o_out(out_ch)
    );

    pmst_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_cfg(cfg_ch), .i_out(out_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > 3_000_000) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // Sink side: random stalls per result, plus one long hold-off on request.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Valid stays high after a transfer; the next item or an idle period takes it over.
    task automatic send_item(input logic [1:0] cmd, input int fv, input int tv, input int wt);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.from_vertex <= fv[VX_W-1:0];
        in_ch.to_vertex   <= tv[VX_W-1:0];
        in_ch.weight      <= wt[WEIGHT_BITS-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop sending and wait until the block is idle and every result is in.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !in_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_count(input int cnt);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cnt[CNT_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int n, kind;
        hold_sink = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.cmd <= CMD_CLEAR;
        in_ch.from_vertex <= '0;
        in_ch.to_vertex <= '0;
        in_ch.weight <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-width graph at reset count, repeats, self entry, extremes.
        send_item(CMD_ADD, 0, 63, 65535);
        send_item(CMD_ADD, 0, 1, 9);
        send_item(CMD_ADD, 0, 1, 0);
        send_item(CMD_ADD, 1, 1, 0);
        send_item(CMD_ADD, 63, 2, 7);
        send_item(CMD_ADD, 1, 2, 7);
        send_item(CMD_ADD, 2, 3, 21845);
        send_item(2'd3, 63, 63, 65535);
        send_item(CMD_RUN, 0, 0, 0);
        set_count(1);
        send_item(CMD_RUN, 42, 21, 43690);
        set_count(0);
        send_item(CMD_RUN, 0, 0, 0);
        set_count(127);
        send_item(CMD_RUN, 0, 0, 0);
        set_count(4);
        send_item(CMD_ADD, 3, 0, 1);
        send_item(CMD_ADD, 0, 2, 5);
        send_item(CMD_ADD, 2, 1, 5);
        send_item(CMD_RUN, 0, 0, 0);
        // Long sink hold-off while runs pile up behind it.
        hold_sink = 1'b1;
        send_item(CMD_RUN, 0, 0, 0);
        send_item(CMD_RUN, 0, 0, 0);
        send_item(CMD_RUN, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0);
        send_item(CMD_RUN, 0, 0, 0);

        // Random graphs: mostly small graphs with in-range edges, some random noise.
        for (int phase = 0; phase < 8; phase++) begin
            n = (phase == 7) ? 64 : $urandom_range(2, 12);
            set_count(n);
            send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
            for (int k = 0; k < 13; k++) begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                    send_item(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                              ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom));
                else if (kind < 9)
                    send_item(CMD_ADD, $urandom, $urandom, $urandom);
                else
                    send_item(CMD_RUN, $urandom, $urandom, $urandom);
            end
            send_item(CMD_RUN, $urandom, $urandom, $urandom);
            // Pause the sender until everything is back.
            if (phase == 3) drain();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
